// File: rtl/core/mpsra_pkg.sv
// Shared types and constants for the multi-page shelf rectangle allocator.
// No dependencies; imported by every module of the block but mpsra_ram.
package mpsra_pkg;

	localparam int COORD_W = 13;   // cursor, shelf and page-size width
	localparam int GUT_W   = 12;
	localparam int LIM_W   = 4;
	localparam int PAD_W   = 14;   // width + 2*gutter
	localparam int OUT_W   = 12;   // coordinate output width
	localparam int IDX_W   = 2;    // register index width

	localparam logic [IDX_W-1:0] CFG_PAGE_SIZE  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_GUTTER     = 2'd1;
	localparam logic [IDX_W-1:0] CFG_PAGE_LIMIT = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_INVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_PLACED   = 3'd0,
		ST_NEWPAGE  = 3'd1,
		ST_TOOLARGE = 3'd2,
		ST_FULL     = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_SCAN,
		S_OPEN
	} state_t;

	// one page-table entry
	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic [COORD_W-1:0] shelf_h;
	} page_entry_t;

	// verdict on one visited page
	typedef struct packed {
		logic               match;
		logic               fit;
		logic               wrap;
		page_entry_t        wr_entry;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
	} eval_t;

endpackage

// File: rtl/core/multi_page_shelf_rect_allocator_unit.sv
// Shelf rectangle allocator over up to MAX_PAGES square atlas pages.
// Depends on mpsra_pkg, mpsra_ram, mpsra_page_eval.
//
// A transaction is taken when start is high and busy is low; its result shows for one
// cycle with done, the first cycle in which busy is low again, and cannot be held off.
// An invalidate ends in the prep state, a too-large request in the check state. An
// allocation that lands on an open page ends in the scan state at that page; one that
// opens a new page or finds the pages full scans every open page, if any, and ends in
// the open state. The page table sits in one RAM with a registered read, and the
// scan reads and tests one page per cycle.
module multi_page_shelf_rect_allocator_unit #(
	parameter int MAX_PAGES     = 8,
	parameter int MAX_PAGE_SIDE = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [mpsra_pkg::COORD_W-1:0]       width,
	input  logic [mpsra_pkg::COORD_W-1:0]       height,
	input  logic                                mode,
	input  logic                                cfg_we,
	input  logic [mpsra_pkg::IDX_W-1:0]         cfg_index,
	input  logic [mpsra_pkg::COORD_W-1:0]       cfg_wdata,
	output logic                                done,
	output logic [2:0]                          status,
	output logic [2:0]                          page,
	output logic [mpsra_pkg::OUT_W-1:0]         upload_x,
	output logic [mpsra_pkg::OUT_W-1:0]         upload_y,
	output logic [mpsra_pkg::COORD_W-1:0]       upload_w,
	output logic [mpsra_pkg::COORD_W-1:0]       upload_h,
	output logic [mpsra_pkg::OUT_W-1:0]         content_x,
	output logic [mpsra_pkg::OUT_W-1:0]         content_y
);
	import mpsra_pkg::*;

	localparam int PG_AW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W   = $clog2(MAX_PAGES + 1);
	localparam int ENTRY_W = $bits(page_entry_t);

	// configuration
	logic [COORD_W-1:0] page_size_q;
	logic [GUT_W-1:0]   gutter_q;
	logic [LIM_W-1:0]   page_limit_q;

	// transaction
	logic               op_q;
	logic [COORD_W-1:0] w_q;
	logic [COORD_W-1:0] h_q;
	logic               mode_q;
	logic [PAD_W-1:0]   uw_q;
	logic [PAD_W-1:0]   uh_q;
	logic [COORD_W-1:0] ps_q;
	logic [CNT_W-1:0]   lim_q;
	logic [COORD_W-1:0] lim_x_q;
	logic [COORD_W-1:0] lim_y_q;
	logic [PG_AW-1:0]   ev_q;
	logic [CNT_W-1:0]   cnt_q;

	state_t state_q, state_n;

	// RAM port
	logic               ram_we;
	logic [PG_AW-1:0]   ram_waddr;
	page_entry_t        ram_wdata;
	logic [PG_AW-1:0]   ram_raddr;
	page_entry_t        ram_rdata;

	eval_t              ev_res;
	logic               too_large;
	logic               ev_last;
	logic               full;
	logic [COORD_W-1:0] ps_raw;

	// result
	logic               done_n;
	status_t            status_n;
	logic [2:0]         page_n;
	logic [COORD_W-1:0] x_n;
	logic [COORD_W-1:0] y_n;
	logic               fields_n;   // fields carry a placement

	logic               done_q;
	logic [2:0]         status_q;
	logic [2:0]         page_q;
	logic [OUT_W-1:0]   ux_q;
	logic [OUT_W-1:0]   uy_q;
	logic [COORD_W-1:0] uw_out_q;
	logic [COORD_W-1:0] uh_out_q;
	logic [OUT_W-1:0]   cx_q;
	logic [OUT_W-1:0]   cy_q;

	mpsra_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PAGES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mpsra_page_eval u_eval (
		.entry (ram_rdata),
		.mode  (mode_q),
		.lim_x (lim_x_q),
		.lim_y (lim_y_q),
		.uw    (uw_q[COORD_W-1:0]),
		.uh    (uh_q[COORD_W-1:0]),
		.res   (ev_res)
	);

	assign ps_raw    = (page_size_q == '0) ? COORD_W'(1) : page_size_q;
	assign too_large = (uw_q > {1'b0, ps_q}) || (uh_q > {1'b0, ps_q});
	assign ev_last   = (CNT_W'(ev_q) + CNT_W'(1)) == cnt_q;
	assign full      = cnt_q >= lim_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q  <= COORD_W'(1024);
			gutter_q     <= GUT_W'(1);
			page_limit_q <= LIM_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_SIZE:  page_size_q  <= cfg_wdata;
				CFG_GUTTER:     gutter_q     <= cfg_wdata[GUT_W-1:0];
				CFG_PAGE_LIMIT: page_limit_q <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_n = S_PREP;
			S_PREP:  state_n = (op_q == OP_INVAL) ? S_IDLE : S_CHECK;
			S_CHECK: begin
				if (too_large)
					state_n = S_IDLE;
				else if (cnt_q == '0)
					state_n = S_OPEN;
				else
					state_n = S_SCAN;
			end
			S_SCAN: begin
				if (ev_res.match && ev_res.fit)
					state_n = S_IDLE;
				else if (ev_last)
					state_n = S_OPEN;
			end
			S_OPEN:  state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// outputs: RAM access and result
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ev_q;
		ram_wdata = ev_res.wr_entry;
		ram_raddr = (state_q == S_CHECK) ? '0 : ev_q + PG_AW'(1);
		done_n    = 1'b0;
		status_n  = ST_PLACED;
		page_n    = '0;
		x_n       = '0;
		y_n       = '0;
		fields_n  = 1'b0;
		unique case (state_q)
			S_PREP: begin
				if (op_q == OP_INVAL) begin
					done_n   = 1'b1;
					status_n = ST_INVALID;
				end
			end
			S_CHECK: begin
				if (too_large) begin
					done_n   = 1'b1;
					status_n = ST_TOOLARGE;
				end
			end
			S_SCAN: begin
				ram_we = ev_res.match && (ev_res.fit || ev_res.wrap);
				if (ev_res.match && ev_res.fit) begin
					done_n   = 1'b1;
					status_n = ST_PLACED;
					page_n   = 3'(ev_q);
					x_n      = ev_res.pos_x;
					y_n      = ev_res.pos_y;
					fields_n = 1'b1;
				end
			end
			S_OPEN: begin
				done_n = 1'b1;
				if (full) begin
					status_n = ST_FULL;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[PG_AW-1:0];
					ram_wdata = '{mode: mode_q, cur_x: uw_q[COORD_W-1:0], cur_y: '0,
						shelf_h: uh_q[COORD_W-1:0]};
					status_n  = ST_NEWPAGE;
					page_n    = 3'(cnt_q);
					fields_n  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ev_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= done_n;
			if (state_q == S_PREP && op_q == OP_INVAL)
				cnt_q <= '0;
			else if (state_q == S_OPEN && !full)
				cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == S_CHECK)
				ev_q <= '0;
			else if (state_q == S_SCAN)
				ev_q <= ev_q + PG_AW'(1);
		end
	end

	// transaction datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q   <= op;
			w_q    <= width;
			h_q    <= height;
			mode_q <= mode;
		end
		if (state_q == S_PREP) begin
			uw_q <= {1'b0, w_q} + {1'b0, gutter_q, 1'b0};
			uh_q <= {1'b0, h_q} + {1'b0, gutter_q, 1'b0};
			ps_q <= (32'(ps_raw) > MAX_PAGE_SIDE) ? COORD_W'(MAX_PAGE_SIDE) : ps_raw;
			lim_q <= (32'(page_limit_q) > MAX_PAGES) ? CNT_W'(MAX_PAGES)
				: CNT_W'(page_limit_q);
		end
		if (state_q == S_CHECK) begin
			// valid only when the padded rectangle fits the page
			lim_x_q <= ps_q - uw_q[COORD_W-1:0];
			lim_y_q <= ps_q - uh_q[COORD_W-1:0];
		end
		if (done_n) begin
			status_q <= status_n;
			page_q   <= page_n;
			ux_q     <= x_n[OUT_W-1:0];
			uy_q     <= y_n[OUT_W-1:0];
			cx_q     <= fields_n ? x_n[OUT_W-1:0] + gutter_q : '0;
			cy_q     <= fields_n ? y_n[OUT_W-1:0] + gutter_q : '0;
			uw_out_q <= fields_n ? uw_q[COORD_W-1:0] : '0;
			uh_out_q <= fields_n ? uh_q[COORD_W-1:0] : '0;
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign status    = status_q;
	assign page      = page_q;
	assign upload_x  = ux_q;
	assign upload_y  = uy_q;
	assign upload_w  = uw_out_q;
	assign upload_h  = uh_out_q;
	assign content_x = cx_q;
	assign content_y = cy_q;

endmodule

// File: rtl/core/mpsra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mpsra_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/mpsra_page_eval.sv
// Shelf test on one page entry: wrap to a new shelf, vertical room, placement.
// Depends on mpsra_pkg.
module mpsra_page_eval (
	input  mpsra_pkg::page_entry_t             entry,
	input  logic                               mode,
	input  logic [mpsra_pkg::COORD_W-1:0]      lim_x,
	input  logic [mpsra_pkg::COORD_W-1:0]      lim_y,
	input  logic [mpsra_pkg::COORD_W-1:0]      uw,
	input  logic [mpsra_pkg::COORD_W-1:0]      uh,
	output mpsra_pkg::eval_t                   res
);
	import mpsra_pkg::*;

	logic               wrap;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic [COORD_W-1:0] sh;
	logic               fit;

	always_comb begin
		wrap = entry.cur_x > lim_x;
		cx   = wrap ? '0 : entry.cur_x;
		cy   = wrap ? entry.cur_y + entry.shelf_h : entry.cur_y;
		sh   = wrap ? '0 : entry.shelf_h;
		fit  = cy <= lim_y;

		res.match = entry.mode == mode;
		res.fit   = fit;
		res.wrap  = wrap;
		res.pos_x = cx;
		res.pos_y = cy;
		res.wr_entry.mode  = mode;
		res.wr_entry.cur_y = cy;
		if (fit) begin
			res.wr_entry.cur_x   = cx + uw;
			res.wr_entry.shelf_h = (uh > sh) ? uh : sh;
		end else begin
			// skipped page keeps only the shelf wrap
			res.wr_entry.cur_x   = '0;
			res.wr_entry.shelf_h = '0;
		end
	end

endmodule

// File: rtl/core/mpsra_chk.sv
// Port-level checks for the shelf rectangle allocator, bound to its top level.
// Depends on mpsra_pkg and multi_page_shelf_rect_allocator_unit.
module mpsra_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [2:0]                    status,
	input logic [2:0]                    page,
	input logic [mpsra_pkg::COORD_W-1:0] upload_w,
	input logic [mpsra_pkg::COORD_W-1:0] upload_h
);
	import mpsra_pkg::*;

	// an accepted transaction keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// busy only ends with a result
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> busy || done)
		else $error("busy dropped without a result");

	// a result is never shown while work is still in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(done))
		else $error("result strobe overlaps busy or repeats");

	// results without a placement carry zero fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_TOOLARGE || status == ST_FULL || status == ST_INVALID)
		|-> page == '0 && upload_w == '0 && upload_h == '0)
		else $error("non-placement result carries field data");

endmodule

bind multi_page_shelf_rect_allocator_unit mpsra_chk u_mpsra_chk (.*);
